>>> hdl/websocket_frame_deframer_core_assert.svh
// Assertion macros for the WebSocket frame deframer core.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property check on clk_i, off while rst_ni is low.
`define WSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Same-cycle implication on clk_i, off while rst_ni is low.
`define WSD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define WSD_ASSERT(label, prop, msg)
`define WSD_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

>>> hdl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_H0    = 3'd0,
    PH_H1    = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_PAY   = 3'd5,
    PH_TAIL  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HDR_TRUNC = 2'd1,
    ST_PAY_TRUNC = 2'd2
  } status_e;

  localparam logic [6:0] LEN7_EXT16   = 7'd126;  // 16-bit extended length follows
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  in_byte;
  } in_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        done_res;
    status_e     status;
    logic        fin_bit;
    logic [2:0]  rsv_bits;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
  } result_t;

endpackage

>>> hdl/wsd_in_stage.sv
// Input register of the deframer: holds one request until the parser takes it.
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     take_i,   // parser consumes the held request this cycle
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

>>> hdl/wsd_parser.sv
// Frame parser: header/length/key state and per-byte unmasking.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,     // one input byte is processed
  input  in_item_t item_i,
  output logic     produce_o,  // this byte yields a result
  output result_t  result_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [63:0] idx_q, idx_d;
  logic [8:0]  hf_q, hf_d;

  logic [7:0]  b;
  logic        fend;
  logic [3:0]  cnt_inc;
  logic [3:0]  cnt_lim;
  logic [63:0] idx_inc;
  logic [7:0]  key_byte;
  logic        valid;
  logic        last;
  logic [7:0]  pbyte;
  status_e     status;

  assign b    = item_i.in_byte;
  assign fend = item_i.frame_end;
  assign cnt_inc = cnt_q + 4'd1;
  assign idx_inc = idx_q + 64'd1;
  assign cnt_lim = (phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;

  always_comb begin
    case (idx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    key_d   = key_q;
    idx_d   = idx_q;
    hf_d    = hf_q;
    valid   = 1'b0;
    last    = 1'b0;
    pbyte   = 8'h00;
    status  = ST_OK;

    case (phase_q)
      PH_H1: begin
        hf_d = {b[7], hf_q[7:0]};
        cnt_d = 4'd0;
        if (b[6:0] < LEN7_EXT16) begin
          len_d = {57'd0, b[6:0]};
          if (b[7]) begin
            phase_d = PH_KEY;
          end else begin
            phase_d = (b[6:0] == 7'd0) ? PH_TAIL : PH_PAY;
          end
        end else begin
          len_d   = 64'd0;
          phase_d = (b[6:0] == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_d = {len_q[55:0], b};
        cnt_d = cnt_inc;
        if (cnt_inc >= cnt_lim) begin
          cnt_d = 4'd0;
          if (hf_q[8]) begin
            phase_d = PH_KEY;
          end else begin
            phase_d = (len_d == 64'd0) ? PH_TAIL : PH_PAY;
          end
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], b};
        cnt_d = cnt_inc;
        if (cnt_inc >= KEY_BYTES) begin
          cnt_d   = 4'd0;
          phase_d = (len_q == 64'd0) ? PH_TAIL : PH_PAY;
        end
      end
      PH_PAY: begin
        pbyte = b ^ key_byte;
        valid = 1'b1;
        idx_d = idx_inc;
        if (idx_inc >= len_q) begin
          last    = 1'b1;
          phase_d = PH_TAIL;
        end
      end
      PH_TAIL: begin
      end
      default: begin  // first header byte, also the unused phase code
        hf_d    = {1'b0, b};
        len_d   = 64'd0;
        key_d   = 32'd0;
        idx_d   = 64'd0;
        cnt_d   = 4'd0;
        phase_d = PH_H1;
      end
    endcase

    if (fend) begin
      if (phase_d == PH_PAY) begin
        status = ST_PAY_TRUNC;
      end else if (phase_d == PH_TAIL) begin
        status = ST_OK;
      end else begin
        status = ST_HDR_TRUNC;
      end
    end

    produce_o = valid || fend;
    result_o.byte_valid     = valid;
    result_o.payload_byte   = pbyte;
    result_o.payload_last   = last;
    result_o.done_res       = fend;
    result_o.status         = status;
    result_o.fin_bit        = hf_d[7];
    result_o.rsv_bits       = hf_d[6:4];
    result_o.opcode         = hf_d[3:0];
    result_o.masked         = hf_d[8];
    result_o.payload_length = len_d;

    // frame end returns to the first header byte with all fields cleared
    if (fend) begin
      phase_d = PH_H0;
      cnt_d   = 4'd0;
      len_d   = 64'd0;
      key_d   = 32'd0;
      idx_d   = 64'd0;
      hf_d    = 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0;
      cnt_q   <= 4'd0;
      len_q   <= 64'd0;
      key_q   <= 32'd0;
      idx_q   <= 64'd0;
      hf_q    <= 9'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
      hf_q    <= hf_d;
    end
  end

endmodule

>>> hdl/wsd_out_stage.sv
// Result register of the deframer, held while the downstream side stalls.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,     // register may take a new value
  input  logic    valid_i,
  input  result_t result_i,
  input  logic    ready_i,
  output logic    advance_o,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign advance_o = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign result_o  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_i && valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

>>> hdl/websocket_frame_deframer_core.sv
// Top level of the WebSocket (RFC 6455) receive-side frame deframer.
//
//  channel  | dir | handshake             | contents
//  ---------+-----+-----------------------+-----------------------------------------
//  s_axis   | in  | tvalid/tready         | tdata: frame byte; tlast: last frame byte
//  m_axis   | out | tvalid/tready         | tdata: payload byte + header/status;
//           |     |                       | tuser: byte_valid; tlast: done_res
//
//  One byte request per clock while m_axis is not stalled; throughput is then one byte per cycle.
//  Each byte passes the input register, then parse/unmask into the result register.
//  Bytes that give no result (header, key, trailing bytes) only update parser state.
//  Reset (rst_ni low, asynchronous) returns the parser to the first header byte.
//  A stalled m_axis holds the result; s_axis keeps taking one more request into
//  the input register, then backs off until the result is taken.
`include "websocket_frame_deframer_core_assert.svh"
module websocket_frame_deframer_core
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] payload_last, [10:9] status, [11] fin_bit,
  // [14:12] rsv_bits, [18:15] opcode, [19] masked, [83:20] payload_length,
  // [87:84] zero
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // done_res
);

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     advance;
  logic     step;
  logic     produce;
  result_t  step_res;
  result_t  out_res;

  assign in_item.in_byte   = s_axis_tdata;
  assign in_item.frame_end = s_axis_tlast;

  // parser moves only when the result register can take what it yields
  assign step = held_valid && advance;

  wsd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (held_item),
    .produce_o (produce),
    .result_o  (step_res)
  );

  wsd_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .valid_i   (produce),
    .result_i  (step_res),
    .ready_i   (m_axis_tready),
    .advance_o (advance),
    .valid_o   (m_axis_tvalid),
    .result_o  (out_res)
  );

  assign m_axis_tdata = {4'd0,
                         out_res.payload_length,
                         out_res.masked,
                         out_res.opcode,
                         out_res.rsv_bits,
                         out_res.fin_bit,
                         out_res.status,
                         out_res.payload_last,
                         out_res.payload_byte};
  assign m_axis_tuser = out_res.byte_valid;
  assign m_axis_tlast = out_res.done_res;

  // every result is a payload byte, an end-of-frame report, or both
  `WSD_ASSERT_IMPLY(a_result_kind, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "result without byte or done")
  // payload_last only ever marks a payload byte
  `WSD_ASSERT_IMPLY(a_last_is_byte, m_axis_tvalid && m_axis_tdata[8], m_axis_tuser, "payload_last on non-byte result")
  // non-ok status only accompanies the end-of-frame report, and is a defined code
  `WSD_ASSERT_IMPLY(a_status_done, m_axis_tvalid && (m_axis_tdata[10:9] != ST_OK), m_axis_tlast && ((m_axis_tdata[10:9] == ST_HDR_TRUNC) || (m_axis_tdata[10:9] == ST_PAY_TRUNC)), "bad status")
  // a parser step is never lost: a held request with room downstream is consumed
  `WSD_ASSERT(a_no_drop, !(held_valid && advance) || s_axis_tready, "input register stuck")

endmodule

>>> tb/websocket_frame_deframer_core_test.sv
// Self-checking testbench for the WebSocket frame deframer core: frame stimulus, prediction, checks.
`timescale 1ns / 100ps

module websocket_frame_deframer_core_test;
  import wsd_pkg::*;

  // One queued request plus a flag that holds it back until all results are in.
  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } frame_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  websocket_frame_deframer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Stimulus and scoreboard storage.
  frame_req_t frame_byte_queue[$];
  result_t    deframed_due[$];
  frame_req_t drv_req;
  bit         drv_holding = 1'b0;
  result_t    mon_got;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned frames_queued = 0;
  int unsigned reqs_accepted = 0;
  int unsigned payload_checked = 0;
  int unsigned done_by_status[3] = '{0, 0, 0};

  // Predictor state: mirror of the parser.
  phase_e      rx_phase = PH_H0;
  logic [3:0]  rx_cnt = '0;
  logic [63:0] rx_len = '0;
  logic [31:0] rx_key = '0;
  logic [63:0] rx_idx = '0;
  logic [8:0]  rx_flags = '0;   // [7:0] first header byte, [8] MASK

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_rx();
    rx_phase = PH_H0;
    rx_cnt   = '0;
    rx_len   = '0;
    rx_key   = '0;
    rx_idx   = '0;
    rx_flags = '0;
  endfunction

  // Header fully parsed: zero length skips straight to trailing bytes.
  function automatic void header_parsed();
    rx_cnt   = '0;
    rx_phase = (rx_len == 64'd0) ? PH_TAIL : PH_PAY;
  endfunction

  function automatic void length_parsed();
    rx_cnt = '0;
    if (rx_flags[8]) begin
      rx_phase = PH_KEY;
    end else begin
      header_parsed();
    end
  endfunction

  // Advance the parser by one frame byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input in_item_t it, output result_t r);
    logic [6:0]  len7;
    logic [31:0] key_sh;
    r = '0;
    case (rx_phase)
      PH_H1: begin
        rx_flags[8] = it.in_byte[7];
        len7 = it.in_byte[6:0];
        if (len7 < LEN7_EXT16) begin
          rx_len = {57'd0, len7};
          length_parsed();
        end else begin
          rx_len   = '0;
          rx_cnt   = '0;
          rx_phase = (len7 == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
        end
      end
      PH_EXT16, PH_EXT64: begin
        rx_len = {rx_len[55:0], it.in_byte};
        rx_cnt = rx_cnt + 4'd1;
        if (rx_cnt >= ((rx_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
          length_parsed();
        end
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], it.in_byte};
        rx_cnt = rx_cnt + 4'd1;
        if (rx_cnt >= KEY_BYTES) begin
          header_parsed();
        end
      end
      PH_PAY: begin
        // key byte 0 (first received) sits in bits 31..24
        key_sh = rx_key >> {~rx_idx[1:0], 3'b000};
        r.payload_byte = it.in_byte ^ key_sh[7:0];
        r.byte_valid   = 1'b1;
        rx_idx = rx_idx + 64'd1;
        if (rx_idx >= rx_len) begin
          r.payload_last = 1'b1;
          rx_phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
      end
      default: begin
        rx_flags = {1'b0, it.in_byte};
        rx_len   = '0;
        rx_key   = '0;
        rx_idx   = '0;
        rx_cnt   = '0;
        rx_phase = PH_H1;
      end
    endcase

    if (!r.byte_valid && !it.frame_end) return 1'b0;

    if (it.frame_end) begin
      if (rx_phase == PH_PAY) r.status = ST_PAY_TRUNC;
      else if (rx_phase == PH_TAIL) r.status = ST_OK;
      else r.status = ST_HDR_TRUNC;
    end
    r.done_res       = it.frame_end;
    r.fin_bit        = rx_flags[7];
    r.rsv_bits       = rx_flags[6:4];
    r.opcode         = rx_flags[3:0];
    r.masked         = rx_flags[8];
    r.payload_length = rx_len;
    if (it.frame_end) clear_rx();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  function automatic void check_result(input result_t exp_r, input result_t act_r);
    string diff;
    diff = "";
    if (act_r.byte_valid !== exp_r.byte_valid) diff = {diff, " byte_valid"};
    if (act_r.payload_byte !== exp_r.payload_byte) diff = {diff, " payload_byte"};
    if (act_r.payload_last !== exp_r.payload_last) diff = {diff, " payload_last"};
    if (act_r.done_res !== exp_r.done_res) diff = {diff, " done_res"};
    if (act_r.status !== exp_r.status) diff = {diff, " status"};
    if (act_r.fin_bit !== exp_r.fin_bit) diff = {diff, " fin_bit"};
    if (act_r.rsv_bits !== exp_r.rsv_bits) diff = {diff, " rsv_bits"};
    if (act_r.opcode !== exp_r.opcode) diff = {diff, " opcode"};
    if (act_r.masked !== exp_r.masked) diff = {diff, " masked"};
    if (act_r.payload_length !== exp_r.payload_length) diff = {diff, " payload_length"};
    if (diff != "") begin
      report_failure($sformatf("result mismatch in%s: expected %h, got %h",
                               diff, exp_r, act_r));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  // Queue one frame's bytes; frame_end rides on the last one.
  function automatic int queue_bytes(input logic [7:0] bytes[$], input bit wait_drain);
    frame_req_t req;
    foreach (bytes[i]) begin
      req.item.in_byte   = bytes[i];
      req.item.frame_end = (i == bytes.size() - 1);
      req.wait_drain     = wait_drain && (i == 0);
      frame_byte_queue = {frame_byte_queue, req};
    end
    frames_queued++;
    return bytes.size();
  endfunction

  // Random frame. Well-formed ones carry their full payload plus up to two trailing
  // bytes; broken ones are cut at a random point, which may truncate the header or payload.
  function automatic int queue_frame(input bit well_formed, input bit wait_drain);
    logic [7:0]  bytes[$];
    logic [63:0] len;
    logic [31:0] key;
    logic [6:0]  len7;
    bit          msk;
    int          kind, n_ext, n_pay, cut;
    bytes = {bytes, 8'($urandom)};       // FIN, RSV, opcode all random
    msk  = 1'($urandom_range(1));
    kind = $urandom_range(9);
    n_ext = 0;
    if (kind < 6) begin
      len = 64'($urandom_range(10));
    end else if (kind == 6) begin
      len = 64'($urandom_range(100, 125));
    end else if (kind == 7) begin
      len = well_formed ? 64'($urandom_range(16)) : 64'($urandom_range(65535));
      n_ext = 2;
    end else begin
      len = well_formed ? 64'($urandom_range(16)) : {$urandom, $urandom};
      n_ext = 8;
    end
    len7 = (n_ext == 0) ? len[6:0] : (n_ext == 2) ? LEN7_EXT16 : 7'h7F;
    bytes = {bytes, {msk, len7}};
    for (int i = n_ext - 1; i >= 0; i--) bytes = {bytes, len[8*i +: 8]};
    if (msk) begin
      key = $urandom;
      for (int i = 3; i >= 0; i--) bytes = {bytes, key[8*i +: 8]};
    end
    n_pay = (len > 64'd24) ? ((kind == 6) ? int'(len) : 24) : int'(len);
    for (int i = 0; i < n_pay; i++) bytes = {bytes, 8'($urandom)};
    if (well_formed) begin
      repeat ($urandom_range(2)) bytes = {bytes, 8'($urandom)};
    end else begin
      cut = $urandom_range(1, bytes.size());
      bytes = bytes[0:cut-1];
    end
    return queue_bytes(bytes, wait_drain);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_t r;
        if (deframe_byte(drv_req.item, r)) deframed_due = {deframed_due, r};
        reqs_accepted++;
        drv_holding = 1'b0;
      end
      if (!drv_holding) begin
        if (frame_byte_queue.size() != 0 &&
            !(frame_byte_queue[0].wait_drain && deframed_due.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          drv_req = frame_byte_queue.pop_front();
          drv_holding = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_req.item.in_byte;
          s_axis_tlast  <= drv_req.item.frame_end;
        end else begin
          // idle: junk on the data lines must be ignored
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= 8'($urandom);
          s_axis_tlast  <= 1'($urandom);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each taken result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got.byte_valid     = m_axis_tuser;
        mon_got.payload_byte   = m_axis_tdata[7:0];
        mon_got.payload_last   = m_axis_tdata[8];
        mon_got.done_res       = m_axis_tlast;
        mon_got.status         = status_e'(m_axis_tdata[10:9]);
        mon_got.fin_bit        = m_axis_tdata[11];
        mon_got.rsv_bits       = m_axis_tdata[14:12];
        mon_got.opcode         = m_axis_tdata[18:15];
        mon_got.masked         = m_axis_tdata[19];
        mon_got.payload_length = m_axis_tdata[83:20];
        if (deframed_due.size() == 0) begin
          report_failure($sformatf("unexpected result %h", mon_got));
        end else begin
          if (deframed_due[0].byte_valid) payload_checked++;
          if (deframed_due[0].done_res) done_by_status[deframed_due[0].status]++;
          check_result(deframed_due.pop_front(), mon_got);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  bytes[$];
    int unsigned n;
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 53, 0, 34};
    stall_set = '{0, 0, 53, 34};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames.
    bytes = '{8'hFF};                          // ends on the first header byte
    void'(queue_bytes(bytes, 1'b0));
    bytes = '{8'h81, 8'h00};                   // FIN text frame, empty payload
    void'(queue_bytes(bytes, 1'b0));
    bytes = '{8'h8A, 8'h82, 8'h12, 8'h34, 8'h56, 8'h78, 8'hAB, 8'hCD};  // masked pong
    void'(queue_bytes(bytes, 1'b0));
    bytes = '{8'h70, 8'h7E, 8'h00, 8'h01, 8'h5A, 8'h33};  // 16-bit length, trailing byte
    void'(queue_bytes(bytes, 1'b0));
    bytes = '{8'h0F, 8'hFF, 8'hFF, 8'hFF};     // cut inside the 64-bit length
    void'(queue_bytes(bytes, 1'b0));
    bytes = '{8'h82, 8'h05, 8'hAA};            // payload cut short
    void'(queue_bytes(bytes, 1'b0));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      n = 0;
      while (n < 150) begin
        n += queue_frame($urandom_range(99) < 80, (n == 0) || ($urandom_range(19) == 0));
      end
      while (frame_byte_queue.size() != 0 || drv_holding) @(posedge clk_i);
    end

    while (deframed_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d frames (%0d byte requests) under four idle/stall mixes;",
             frames_queued, reqs_accepted);
    $display("checked %0d payload bytes, frame ends ok/hdr-trunc/pay-trunc: %0d/%0d/%0d",
             payload_checked, done_by_status[ST_OK], done_by_status[ST_HDR_TRUNC],
             done_by_status[ST_PAY_TRUNC]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", deframed_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
